/* rtl/core/igu_pkg.sv */
package igu_pkg;

  // Field widths
  localparam int unsigned COMP_W     = 10;
  localparam int unsigned VOLT_W     = 16;
  localparam int unsigned PEAK_W     = 16;
  localparam int unsigned GATE_W     = 17;
  localparam int unsigned COND_W     = 16;
  localparam int unsigned CUR_W      = 32;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Compartment stores; the address is the low bits of the compartment index
  localparam int unsigned COMPARTMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(COMPARTMENTS);

  // Sigmoid table
  localparam int unsigned SIGMOID_ENTRIES = 256;
  localparam int unsigned ROM_LAST        = SIGMOID_ENTRIES - 1;
  localparam int unsigned ROM_IDX_W       = $clog2(SIGMOID_ENTRIES);
  localparam int          ROM_LOW         = -20480;  // -80 mV in Q8.8
  localparam int          ROM_SPAN        = 16384;   // 64 mV in Q8.8
  localparam int unsigned SPAN_W          = $clog2(ROM_SPAN);
  localparam int          VHALF_X2560     = -122368; // -47.8 mV
  localparam int          SLOPE_X2560     = 7936;    // 3.1 mV
  localparam longint unsigned EXP_M1_Q32  = 64'd1580030169;

  localparam int unsigned GATE_FRAC = 16;
  localparam int          ONE_Q16   = 65536;

  typedef enum logic {
    OP_INIT   = 1'b0,
    OP_UPDATE = 1'b1
  } igu_opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_INF  = 2'd0,
    CFG_COEF_PREV = 2'd1,
    CFG_REVERSAL  = 2'd2
  } igu_cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_INTERP,
    S_MINF,
    S_MUL,
    S_SUM,
    S_COND,
    S_CUR
  } igu_state_e;

  typedef struct packed {
    logic cap_in;
    logic cap_idx;
    logic cap_interp;
    logic cap_minf;
    logic cap_mul;
    logic cap_sum;
    logic cap_cond;
    logic cap_out;
  } igu_cmd_t;

  typedef struct packed {
    logic out_stall;
  } igu_sts_t;

  // Steady-state gate at table entry idx, Q1.16; evaluated at elaboration only
  function automatic logic [GATE_W-1:0] sig_entry(input int unsigned idx);
    longint d;
    longint sum;
    longint unsigned a, t, n, f, term, r, e, num, Den, Den7, Kdiv;
    int unsigned k;
    Den7 = longint'(SLOPE_X2560) * longint'(ROM_LAST);
    d = (longint'(10 * ROM_LOW) - longint'(VHALF_X2560)) * longint'(ROM_LAST)
        + longint'(10) * longint'(idx) * longint'(ROM_SPAN);
    a = (d < 0) ? longint'(-d) : d;
    t = (a * 64'd65536 + Den7 / 2) / Den7;
    n = t >> 16;
    f = t & 64'hFFFF;
    if (n >= 32) begin
      e = 0;
    end else begin
      term = 64'd1 << 32;
      sum  = longint'(64'd1 << 32);
      for (k = 1; k <= 12; k++) begin
        Kdiv = 64'd65536 * k;
        term = (term * f) / Kdiv;
        if (k[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      r = sum;
      for (k = 0; k < 32; k++) begin
        if (k < n) begin
          r = (r * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
        end
      end
      e = r;
    end
    Den = (64'd1 << 32) + e;
    num = (d >= 0) ? (64'd1 << 32) : e;
    return GATE_W'((num * 64'd65536 + Den / 2) / Den);
  endfunction

endpackage

/* rtl/core/igu_in_if.sv */
interface igu_in_if import igu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [COMP_W-1:0]        compartment;
  logic signed [VOLT_W-1:0] voltage;
  logic [PEAK_W-1:0]        peak_conductance;

  modport source (
    output valid, opcode, compartment, voltage, peak_conductance,
    input  ready
  );

  modport sink (
    input  valid, opcode, compartment, voltage, peak_conductance,
    output ready
  );
endinterface

/* rtl/core/igu_out_if.sv */
interface igu_out_if import igu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COMP_W-1:0]       out_compartment;
  logic [GATE_W-1:0]       gate;
  logic [COND_W-1:0]       conductance;
  logic signed [CUR_W-1:0] current;

  modport source (
    output valid, out_compartment, gate, conductance, current,
    input  ready
  );

  modport sink (
    input  valid, out_compartment, gate, conductance, current,
    output ready
  );
endinterface

/* rtl/core/igu_ram.sv */
module igu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/igu_ctrl.sv */
module igu_ctrl import igu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  igu_sts_t sts_i,
  output igu_cmd_t cmd_o
);

  igu_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = S_IDX;
        end
      end
      S_IDX: begin
        cmd_o.cap_idx = 1'b1;
        state_d       = S_INTERP;
      end
      S_INTERP: begin
        cmd_o.cap_interp = 1'b1;
        state_d          = S_MINF;
      end
      S_MINF: begin
        cmd_o.cap_minf = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.cap_mul = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.cap_sum = 1'b1;
        state_d       = S_COND;
      end
      S_COND: begin
        cmd_o.cap_cond = 1'b1;
        state_d        = S_CUR;
      end
      S_CUR: begin
        // hold until the output register is free
        if (!sts_i.out_stall) begin
          cmd_o.cap_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/igu_dp.sv */
module igu_dp import igu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  igu_cmd_t                 cmd_i,
  output igu_sts_t                 sts_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_opcode_i,
  input  logic [COMP_W-1:0]        in_compartment_i,
  input  logic signed [VOLT_W-1:0] in_voltage_i,
  input  logic [PEAK_W-1:0]        in_peak_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [COMP_W-1:0]        out_compartment_o,
  output logic [GATE_W-1:0]        gate_o,
  output logic [COND_W-1:0]        conductance_o,
  output logic signed [CUR_W-1:0]  current_o
);

  localparam int unsigned U_W      = VOLT_W + 2;
  localparam int unsigned UCL_W    = SPAN_W + 1;
  localparam int unsigned SCALED_W = UCL_W + ROM_IDX_W;
  localparam int unsigned PROD_W   = GATE_W + 1 + SPAN_W + 1;
  localparam int unsigned P1_W     = COEF_W + GATE_W;
  localparam int unsigned P2_W     = COEF_W + GATE_W + 1;
  localparam int unsigned SUM_W    = P2_W + 1;
  localparam int unsigned GP_W     = PEAK_W + GATE_W;
  localparam int unsigned CURP_W   = COND_W + 1 + VOLT_W + 1;

  // Sigmoid table, folded to constants
  logic [GATE_W-1:0] rom_tab [SIGMOID_ENTRIES];
  for (genvar gi = 0; gi < SIGMOID_ENTRIES; gi++) begin : g_rom
    localparam logic [GATE_W-1:0] Entry = sig_entry(gi);
    assign rom_tab[gi] = Entry;
  end

  // Configuration
  logic [COEF_W-1:0]        coef_inf_q;
  logic signed [COEF_W-1:0] coef_prev_q;
  logic signed [VOLT_W-1:0] rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_inf_q  <= COEF_W'(1618);
      coef_prev_q <= COEF_W'(63918);
      rev_q       <= VOLT_W'(12800);
    end else if (cfg_we_i) begin
      case (igu_cfg_reg_e'(cfg_index_i))
        CFG_COEF_INF:  coef_inf_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_PREV: coef_prev_q <= $signed(cfg_data_i[COEF_W-1:0]);
        CFG_REVERSAL:  rev_q       <= $signed(cfg_data_i[VOLT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Compartment stores
  logic [ADDR_W-1:0] waddr;
  logic [GATE_W-1:0] gate_rdata, gate_d;
  logic [PEAK_W-1:0] peak_rdata;
  igu_opcode_e       op_q;
  logic [COMP_W-1:0] comp_q;
  logic [PEAK_W-1:0] peak_in_q;

  assign waddr = comp_q[ADDR_W-1:0];

  igu_ram #(
    .WIDTH (GATE_W),
    .DEPTH (COMPARTMENTS)
  ) u_gate_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cap_sum),
    .waddr_i (waddr),
    .wdata_i (gate_d),
    .raddr_i (in_compartment_i[ADDR_W-1:0]),
    .rdata_o (gate_rdata)
  );

  igu_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (COMPARTMENTS)
  ) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cap_sum && (op_q == OP_INIT)),
    .waddr_i (waddr),
    .wdata_i (peak_in_q),
    .raddr_i (in_compartment_i[ADDR_W-1:0]),
    .rdata_o (peak_rdata)
  );

  // Datapath registers
  logic signed [VOLT_W-1:0] volt_q;
  logic [ROM_IDX_W-1:0]     idx_q, idx_d;
  logic [SPAN_W-1:0]        frac_q, frac_d;
  logic [GATE_W-1:0]        gate_old_q;
  logic [PEAK_W-1:0]        peak_q;
  logic [GATE_W-1:0]        lo_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic [GATE_W-1:0]        mi_q, mi_d;
  logic [P1_W-1:0]          p1_q, p1_d;
  logic signed [P2_W-1:0]   p2_q, p2_d;
  logic [GATE_W-1:0]        gate_q;
  logic [COND_W-1:0]        g_q, g_d;

  // Table position from the clamped voltage
  logic signed [U_W-1:0] u_s;
  logic [UCL_W-1:0]      ucl;
  logic [SCALED_W-1:0]   scaled;

  always_comb begin
    u_s = $signed({{2{volt_q[VOLT_W-1]}}, volt_q}) - $signed(U_W'(ROM_LOW));
    if (u_s < 0) begin
      ucl = '0;
    end else if (u_s > $signed(U_W'(ROM_SPAN))) begin
      ucl = UCL_W'(ROM_SPAN);
    end else begin
      ucl = u_s[UCL_W-1:0];
    end
    scaled = SCALED_W'(ucl) * SCALED_W'(ROM_LAST);
    idx_d  = ROM_IDX_W'(scaled >> SPAN_W);
    frac_d = scaled[SPAN_W-1:0];
  end

  // Interpolation step; the top entry pairs with itself
  logic [ROM_IDX_W-1:0]     hi_idx;
  logic signed [GATE_W:0]   diff_s;

  always_comb begin
    hi_idx = (idx_q == ROM_IDX_W'(ROM_LAST)) ? idx_q : idx_q + ROM_IDX_W'(1);
    diff_s = $signed({1'b0, rom_tab[hi_idx]}) - $signed({1'b0, rom_tab[idx_q]});
    prod_d = PROD_W'(diff_s) * PROD_W'($signed({1'b0, frac_q}));
  end

  // Divide by the span, truncating towards zero
  logic signed [PROD_W-1:0] prod_adj, quot;

  always_comb begin
    prod_adj = prod_q;
    if (prod_q < 0) begin
      prod_adj = prod_q + $signed(PROD_W'(ROM_SPAN - 1));
    end
    quot = prod_adj >>> SPAN_W;
    mi_d = GATE_W'($signed(PROD_W'({1'b0, lo_q})) + quot);
  end

  assign p1_d = P1_W'(coef_inf_q) * P1_W'(mi_q);
  assign p2_d = P2_W'(coef_prev_q) * P2_W'($signed({1'b0, gate_old_q}));

  // Trapezoidal sum, clamped to [0, 1] on update; an init takes the steady-state gate
  logic signed [SUM_W-1:0] sum_s, sum_sh;

  always_comb begin
    sum_s  = $signed({2'b00, p1_q}) + SUM_W'(p2_q);
    sum_sh = sum_s >>> GATE_FRAC;
    if (op_q == OP_INIT) begin
      gate_d = mi_q;
    end else if (sum_s < 0) begin
      gate_d = '0;
    end else if (sum_sh > $signed(SUM_W'(ONE_Q16))) begin
      gate_d = GATE_W'(ONE_Q16);
    end else begin
      gate_d = sum_sh[GATE_W-1:0];
    end
  end

  logic [GP_W-1:0] gp;
  assign gp  = GP_W'(peak_q) * GP_W'(gate_q);
  assign g_d = COND_W'(gp >> GATE_FRAC);

  // Current with saturation to the output range
  logic signed [VOLT_W:0]     dv;
  logic signed [CURP_W-1:0]   curp;
  logic signed [CUR_W-1:0]    cur_d;

  always_comb begin
    dv   = $signed({volt_q[VOLT_W-1], volt_q}) - $signed({rev_q[VOLT_W-1], rev_q});
    curp = CURP_W'($signed({1'b0, g_q})) * CURP_W'(dv);
    if ((&curp[CURP_W-1:CUR_W-1]) || !(|curp[CURP_W-1:CUR_W-1])) begin
      cur_d = curp[CUR_W-1:0];
    end else if (curp[CURP_W-1]) begin
      cur_d = {1'b1, {(CUR_W-1){1'b0}}};
    end else begin
      cur_d = {1'b0, {(CUR_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q      <= igu_opcode_e'(in_opcode_i);
      comp_q    <= in_compartment_i;
      volt_q    <= in_voltage_i;
      peak_in_q <= in_peak_i;
    end
    if (cmd_i.cap_idx) begin
      idx_q      <= idx_d;
      frac_q     <= frac_d;
      gate_old_q <= gate_rdata;
      peak_q     <= (op_q == OP_INIT) ? peak_in_q : peak_rdata;
    end
    if (cmd_i.cap_interp) begin
      lo_q   <= rom_tab[idx_q];
      prod_q <= prod_d;
    end
    if (cmd_i.cap_minf) begin
      mi_q <= mi_d;
    end
    if (cmd_i.cap_mul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (cmd_i.cap_sum) begin
      gate_q <= gate_d;
    end
    if (cmd_i.cap_cond) begin
      g_q <= g_d;
    end
  end

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [COMP_W-1:0]       out_comp_q;
  logic [GATE_W-1:0]       out_gate_q;
  logic [COND_W-1:0]       out_cond_q;
  logic signed [CUR_W-1:0] out_cur_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.cap_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_out) begin
      out_comp_q <= comp_q;
      out_gate_q <= gate_q;
      out_cond_q <= g_q;
      out_cur_q  <= cur_d;
    end
  end

  assign sts_o.out_stall  = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_compartment_o = out_comp_q;
  assign gate_o            = out_gate_q;
  assign conductance_o     = out_cond_q;
  assign current_o         = out_cur_q;

endmodule

/* rtl/core/ion_channel_gate_update_unit.sv */
// An input transfer is registered, then the sequencer walks the store read, table
// interpolation, steady-state gate, gate multiply, clamp, conductance and current
// steps; a new item is taken only once it is idle again after the result is loaded.
// A full output register that is not taken holds the last step until it drains.
// Reset: configuration to its defaults, sequencer idle, output empty; the gate
// and peak stores are not cleared and hold nothing until initialised.
module ion_channel_gate_update_unit import igu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  igu_in_if.sink                in_ch,
  igu_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  igu_cmd_t cmd;
  igu_sts_t sts;
  logic     in_ready;

  igu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  igu_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_opcode_i       (in_ch.opcode),
    .in_compartment_i  (in_ch.compartment),
    .in_voltage_i      (in_ch.voltage),
    .in_peak_i         (in_ch.peak_conductance),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .out_compartment_o (out_ch.out_compartment),
    .gate_o            (out_ch.gate),
    .conductance_o     (out_ch.conductance),
    .current_o         (out_ch.current)
  );

  assign in_ch.ready = in_ready;

  // one item in flight at a time
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath step commanded");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cap_out |=> out_ch.valid)
    else $error("result loaded but output not valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |-> !cmd.cap_out)
    else $error("pending result overwritten");

  a_gate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.gate <= GATE_W'(ONE_Q16))
    else $error("gate above one");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top import igu_pkg::*; ;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOT_COMPS      = 8;
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_BURST   = 210;
  localparam int HOLD_CYCLES    = 300;
  localparam longint CUR_MAX    = 64'sd2147483647;
  localparam longint CUR_MIN    = -64'sd2147483648;

  typedef struct {
    igu_opcode_e              opcode;
    logic [COMP_W-1:0]        compartment;
    logic signed [VOLT_W-1:0] voltage;
    logic [PEAK_W-1:0]        peak;
  } gate_item_t;

  typedef struct {
    logic [COMP_W-1:0]       compartment;
    logic [GATE_W-1:0]       gate;
    logic [COND_W-1:0]       conductance;
    logic signed [CUR_W-1:0] current;
  } gate_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  igu_in_if  in_ch ();
  igu_out_if out_ch ();

  ion_channel_gate_update_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: registers, compartment stores and the steady-state table
  logic [COEF_W-1:0]        coef_inf_q  = 18'd1618;
  logic signed [COEF_W-1:0] coef_prev_q = 18'sd63918;
  logic signed [VOLT_W-1:0] reversal_q  = 16'sd12800;
  logic [GATE_W-1:0]        gate_mem [COMPARTMENTS];
  logic [PEAK_W-1:0]        peak_mem [COMPARTMENTS];
  bit                       seen_init [COMPARTMENTS];
  longint                   minf_table [SIGMOID_ENTRIES];

  gate_result_t expected_steps [$];
  gate_result_t oldest_step;
  logic [COMP_W-1:0] hot_comps [HOT_COMPS];

  int items_sent         = 0;
  int results_checked    = 0;
  int mismatch_count     = 0;
  int clamped_gates      = 0;
  int saturated_currents = 0;
  int settings_used      = 1;
  int send_idle_pct      = 0;
  int stall_pct          = 0;
  int hold_len           = 0;
  bit hold_token         = 1'b0;
  bit hold_seen          = 1'b0;
  int hold_left          = 0;
  int idle_cycles        = 0;

  function automatic void build_minf_table();
    longint d, acc, last;
    longint unsigned a, t, n, f, term, r, e, num, den, den7, k;
    last = ROM_LAST;
    den7 = longint'(SLOPE_X2560) * last;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      d = (10 * longint'(ROM_LOW) - longint'(VHALF_X2560)) * last
          + 10 * longint'(i) * longint'(ROM_SPAN);
      a = (d < 0) ? -d : d;
      t = (a * 64'd65536 + den7 / 2) / den7;
      n = t >> 16;
      f = t & 64'hFFFF;
      if (n >= 32) begin
        e = 0;
      end else begin
        // series for the fractional part, then one factor of 1/e per whole unit
        term = 64'd1 << 32;
        acc  = longint'(64'd1 << 32);
        for (k = 1; k <= 12; k++) begin
          term = term * f / (64'd65536 * k);
          if (k[0]) acc -= longint'(term);
          else acc += longint'(term);
        end
        r = acc;
        for (k = 0; k < n; k++) r = (r * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
        e = r;
      end
      den = (64'd1 << 32) + e;
      num = (d >= 0) ? (64'd1 << 32) : e;
      minf_table[i] = longint'((num * 64'd65536 + den / 2) / den);
    end
  endfunction

  function automatic longint steady_gate(input logic signed [VOLT_W-1:0] v);
    longint u, scaled, idx, frac, last;
    last = ROM_LAST;
    u = longint'(v) - ROM_LOW;
    if (u < 0) u = 0;
    if (u > ROM_SPAN) u = ROM_SPAN;
    scaled = u * last;
    idx    = scaled / ROM_SPAN;
    frac   = scaled % ROM_SPAN;
    if (idx >= last) return minf_table[ROM_LAST];
    return minf_table[idx] + ((minf_table[idx+1] - minf_table[idx]) * frac) / ROM_SPAN;
  endfunction

  function automatic gate_result_t compute_gate_step(input gate_item_t it);
    gate_result_t res;
    longint mi, acc, gate, cond, cur;
    int unsigned addr;
    addr = it.compartment % COMPARTMENTS;
    mi   = steady_gate(it.voltage);
    if (it.opcode == OP_INIT) begin
      peak_mem[addr]  = it.peak;
      seen_init[addr] = 1'b1;
      gate = mi;
    end else begin
      acc = longint'(coef_inf_q) * mi + longint'(coef_prev_q) * longint'(gate_mem[addr]);
      if (acc < 0) begin
        gate = 0;
        clamped_gates++;
      end else begin
        gate = acc >>> 16;
        if (gate > ONE_Q16) begin
          gate = ONE_Q16;
          clamped_gates++;
        end
      end
    end
    gate_mem[addr] = GATE_W'(gate);
    cond = (longint'(peak_mem[addr]) * gate) >>> 16;
    cur  = cond * (longint'(it.voltage) - longint'(reversal_q));
    if (cur > CUR_MAX || cur < CUR_MIN) saturated_currents++;
    if (cur > CUR_MAX) cur = CUR_MAX;
    if (cur < CUR_MIN) cur = CUR_MIN;
    res.compartment = it.compartment;
    res.gate        = GATE_W'(gate);
    res.conductance = COND_W'(cond);
    res.current     = CUR_W'(cur);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int comp,
                                 input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch: %s, compartment %0d: got %0d, expected %0d", what, comp, got, want);
  endtask

  // Output side: check each transfer, then pick the next ready level
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("result with nothing pending", out_ch.out_compartment, out_ch.gate, 0);
      end else begin
        oldest_step = expected_steps.pop_front();
        results_checked++;
        if (out_ch.out_compartment !== oldest_step.compartment)
          report_mismatch("out_compartment", oldest_step.compartment,
                          out_ch.out_compartment, oldest_step.compartment);
        if (out_ch.gate !== oldest_step.gate)
          report_mismatch("gate", oldest_step.compartment, out_ch.gate, oldest_step.gate);
        if (out_ch.conductance !== oldest_step.conductance)
          report_mismatch("conductance", oldest_step.compartment,
                          out_ch.conductance, oldest_step.conductance);
        if (out_ch.current !== oldest_step.current)
          report_mismatch("current", oldest_step.compartment,
                          out_ch.current, oldest_step.current);
      end
    end
    if (hold_token != hold_seen) begin
      hold_left = hold_len;
      hold_seen = hold_token;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input igu_opcode_e op, input int comp, input int v, input int peak);
    gate_item_t it;
    int gap;
    it.opcode      = op;
    it.compartment = COMP_W'(comp);
    it.voltage     = VOLT_W'(v);
    it.peak        = PEAK_W'(peak);
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= op;
    in_ch.compartment      <= it.compartment;
    in_ch.voltage          <= it.voltage;
    in_ch.peak_conductance <= it.peak;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_steps.push_back(compute_gate_step(it));
    items_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item();
    int comp, v, peak, sel;
    igu_opcode_e op;
    if ($urandom_range(1)) comp = hot_comps[$urandom_range(HOT_COMPS-1)];
    else comp = $urandom_range(COMPARTMENTS-1);
    if ($urandom_range(9) == 0) hot_comps[$urandom_range(HOT_COMPS-1)] = COMP_W'(comp);
    // never update a compartment whose stores have not been written
    op = (!seen_init[comp] || $urandom_range(99) < 20) ? OP_INIT : OP_UPDATE;
    sel = $urandom_range(99);
    if (sel < 65) begin
      v = ROM_LOW - 256 + int'($urandom_range(ROM_SPAN + 512));
    end else if (sel < 72) begin
      case ($urandom_range(3))
        0:       v = -32768;
        1:       v = 32767;
        2:       v = ROM_LOW;
        default: v = ROM_LOW + ROM_SPAN;
      endcase
    end else begin
      v = int'($urandom_range(65535)) - 32768;
    end
    sel = $urandom_range(9);
    if (sel == 0) peak = 0;
    else if (sel == 1) peak = 65535;
    else peak = $urandom_range(65535);
    send_item(op, comp, v, peak);
  endtask

  // Drop valid, let every pending result arrive, then let the pipeline settle
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input igu_cfg_reg_e idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    case (idx)
      CFG_COEF_INF:  coef_inf_q  = COEF_W'(value);
      CFG_COEF_PREV: coef_prev_q = COEF_W'(value);
      CFG_REVERSAL:  reversal_q  = VOLT_W'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_coefs(input int ci, input int cp, input int rev);
    write_reg(CFG_COEF_INF, ci);
    write_reg(CFG_COEF_PREV, cp);
    write_reg(CFG_REVERSAL, rev);
    settings_used++;
  endtask

  task automatic test_directed();
    send_item(OP_INIT, 0, -32768, 65535);
    send_item(OP_INIT, 1023, 32767, 65535);
    send_item(OP_INIT, 512, ROM_LOW, 0);
    send_item(OP_INIT, 1, ROM_LOW + ROM_SPAN, 65535);
    send_item(OP_INIT, 2, -12237, 4096);
    send_item(OP_INIT, 3, ROM_LOW + ROM_SPAN - 1, 1);
    send_item(OP_INIT, 341, ROM_LOW - 1, 16'hAAAA);
    // high gate at the most negative voltage pushes the current past its lower bound
    send_item(OP_UPDATE, 1023, -32768, 0);
    // peak field is ignored on update
    send_item(OP_UPDATE, 0, 32767, 12345);
    send_item(OP_UPDATE, 2, 0, 65535);
    send_item(OP_UPDATE, 512, -12237, 65535);
    send_item(OP_UPDATE, 341, -1, 0);
    send_item(OP_INIT, 1023, ROM_LOW + 1, 32768);
    repeat (3) send_item(OP_UPDATE, 1, ROM_LOW + ROM_SPAN, 0);
    send_item(OP_UPDATE, 3, 1, 0);
    send_item(OP_INIT, 682, 12800, 21845);
  endtask

  task automatic test_gate_clamp();
    wait_for_drain();
    set_coefs(131072, 65536, -32768);
    send_item(OP_INIT, 10, 32767, 65535);
    send_item(OP_UPDATE, 10, 32767, 0);
    send_item(OP_UPDATE, 10, -32768, 0);
    wait_for_drain();
    set_coefs(0, -65536, 32767);
    send_item(OP_UPDATE, 10, 0, 0);
    send_item(OP_UPDATE, 10, 0, 0);
    send_item(OP_INIT, 11, ROM_LOW + ROM_SPAN, 32768);
  endtask

  task automatic test_random_phases();
    int send_pct [4] = '{0, 49, 0, 10};
    int recv_pct [4] = '{0, 0, 49, 10};
    int setting, ci, cp, rev;
    for (int p = 0; p < 4; p++) begin
      for (int half = 0; half < 2; half++) begin
        wait_for_drain();
        send_idle_pct = send_pct[p];
        stall_pct <= recv_pct[p];
        setting = 2 * p + half;
        if (setting == 0) begin
          ci = 0;
          cp = 65536;
          rev = -32768;
        end else if (setting == 1) begin
          ci = 131072;
          cp = -65536;
          rev = 32767;
        end else begin
          ci = $urandom_range(131072);
          // a consistent pair sums to one; otherwise pick the two apart
          if ($urandom_range(1)) cp = 65536 - ci;
          else cp = int'($urandom_range(131072)) - 65536;
          rev = int'($urandom_range(65535)) - 32768;
        end
        set_coefs(ci, cp, rev);
        repeat (RANDOM_BURST) send_random_item();
      end
    end
  endtask

  task automatic test_output_hold_off();
    wait_for_drain();
    send_idle_pct = 0;
    stall_pct  <= 0;
    hold_len   <= HOLD_CYCLES;
    hold_token <= ~hold_token;
    // keep offering items while the output is held so the input backs up
    repeat (30) send_random_item();
  endtask

  task automatic test_drain_pause();
    wait_for_drain();
    stall_pct <= 49;
    repeat (20) send_random_item();
    wait_for_drain();
    repeat (20) send_random_item();
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_index_i            = CFG_COEF_INF;
    cfg_data_i             = '0;
    in_ch.valid            = 1'b0;
    in_ch.opcode           = OP_INIT;
    in_ch.compartment      = '0;
    in_ch.voltage          = '0;
    in_ch.peak_conductance = '0;
    out_ch.ready           = 1'b0;
    build_minf_table();
    foreach (hot_comps[i]) hot_comps[i] = COMP_W'($urandom_range(COMPARTMENTS-1));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_gate_clamp();
    test_random_phases();
    test_output_hold_off();
    test_drain_pause();
    wait_for_drain();

    $display("summary: %0d items, %0d results checked over %0d register settings and four idle mixes",
             items_sent, results_checked, settings_used);
    $display("summary: %0d-cycle output hold-off, drain pause, %0d gates clamped, %0d currents saturated",
             HOLD_CYCLES, clamped_gates, saturated_currents);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
